[hw/rtl/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the stimulation cycle sequencer.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int COUNTER_WIDTH_DEF = 16;
	localparam int CFG_W             = 16;
	localparam int CFG_IDX_W         = 3;
	localparam int PERIOD_W          = 18;
	localparam int RELAX_W           = 8;

	localparam logic [PERIOD_W-1:0] TEST_PERIOD_MS = PERIOD_W'(200);
	localparam logic [PERIOD_W-1:0] SHORT_RELAX_MS = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0] MS_PER_S       = PERIOD_W'(1000);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAX        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_BANK  = 3'd5;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_TEST   = 3'd1,
		MODE_UP     = 3'd2,
		MODE_HOLD   = 3'd3,
		MODE_DOWN   = 3'd4,
		MODE_RELAX  = 3'd5,
		MODE_CLIP   = 3'd6,
		MODE_CHARGE = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_BEGIN     = 3'd1,
		CMD_TURN_OFF  = 3'd2,
		CMD_CLIP_OFF  = 3'd3,
		CMD_CLIP_ON   = 3'd4,
		CMD_CHG_ON    = 3'd5,
		CMD_CHG_OFF   = 3'd6,
		CMD_PWR_DIS   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		PCMD_NONE    = 3'd0,
		PCMD_UP      = 3'd1,
		PCMD_DOWN    = 3'd2,
		PCMD_SYNC    = 3'd3,
		PCMD_ZERO    = 3'd4,
		PCMD_ZERO_UP = 3'd5
	} pcmd_t;

	typedef struct packed {
		logic [CFG_W-1:0]   frame_period_ms;
		logic [CFG_W-1:0]   ramp_up_frames;
		logic [CFG_W-1:0]   hold_frames;
		logic [CFG_W-1:0]   ramp_down_frames;
		logic [RELAX_W-1:0] relax_seconds;
		logic [CFG_W-1:0]   cycles_per_bank;
	} cfg_t;

	typedef struct packed {
		mode_t               mode;
		pcmd_t               power_cmd;
		logic                high_voltage_on;
		logic                running;
		logic                tick_enable;
		logic [PERIOD_W-1:0] tick_period_ms;
		logic                burst_start;
		logic                descent_start;
		logic                bank;
	} result_t;

endpackage

[hw/rtl/scs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// scs_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module scs_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_valid,
	output logic                          wr_ready,
	input  logic [scs_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [scs_pkg::CFG_W-1:0]     wr_data,
	output scs_pkg::cfg_t                 cfg
);
	import scs_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period_ms  <= CFG_W'(100);
			cfg_q.ramp_up_frames   <= CFG_W'(10);
			cfg_q.hold_frames      <= CFG_W'(20);
			cfg_q.ramp_down_frames <= CFG_W'(10);
			cfg_q.relax_seconds    <= RELAX_W'(1);
			cfg_q.cycles_per_bank  <= '0;
		end else if (wr_valid) begin
			// indexes past the list are dropped
			case (wr_index)
				CFG_FRAME_PERIOD: cfg_q.frame_period_ms  <= wr_data;
				CFG_RAMP_UP:      cfg_q.ramp_up_frames   <= wr_data;
				CFG_HOLD:         cfg_q.hold_frames      <= wr_data;
				CFG_RAMP_DOWN:    cfg_q.ramp_down_frames <= wr_data;
				CFG_RELAX:        cfg_q.relax_seconds    <= wr_data[RELAX_W-1:0];
				CFG_CYCLES_BANK:  cfg_q.cycles_per_bank  <= wr_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/scs_core.sv]
// ----------------------------------------------------------------------------
// scs_core
// Mode state machine, frame and cycle counters, and status word logic.
// ----------------------------------------------------------------------------
module scs_core #(
	parameter int COUNTER_WIDTH = scs_pkg::COUNTER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  scs_pkg::cmd_t    cmd,
	input  logic             wished,
	input  scs_pkg::cfg_t    cfg,
	output scs_pkg::result_t result
);
	import scs_pkg::*;

	localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

	mode_t                    mode_q, mode_d;
	logic [COUNTER_WIDTH-1:0] frame_q, frame_d, cycle_q, cycle_d;
	logic                     off_pend_q, off_pend_d;
	logic                     hv_q, hv_d, run_q, run_d, tick_en_q, tick_en_d;
	logic [PERIOD_W-1:0]      period_q, period_d;
	logic                     bank_q, bank_d;
	pcmd_t                    pcmd;
	logic                     burst, desc;

	logic [COUNTER_WIDTH-1:0] frame_inc, cycle_inc;
	logic [CMP_W-1:0]         frame_inc_x, cycle_inc_x;
	logic                     in_cycle, tick_live, up_done, hold_done, down_done;
	logic [PERIOD_W-1:0]      frame_period, relax_period;

	assign frame_inc   = frame_q + COUNTER_WIDTH'(1);
	assign cycle_inc   = cycle_q + COUNTER_WIDTH'(1);
	assign frame_inc_x = CMP_W'(frame_inc);
	assign cycle_inc_x = CMP_W'(cycle_inc);

	assign in_cycle  = (mode_q == MODE_UP) || (mode_q == MODE_HOLD) ||
	                   (mode_q == MODE_DOWN) || (mode_q == MODE_RELAX);
	// ticks in off, clip off and charging are dropped
	assign tick_live = (cmd == CMD_TICK) && (in_cycle || (mode_q == MODE_TEST));

	assign up_done   = frame_inc_x >= CMP_W'(cfg.ramp_up_frames);
	assign hold_done = (cfg.hold_frames != '0) &&
	                   (frame_inc_x >= CMP_W'(cfg.hold_frames));
	assign down_done = frame_inc_x >= CMP_W'(cfg.ramp_down_frames);

	assign frame_period = PERIOD_W'(cfg.frame_period_ms);
	assign relax_period = (cfg.relax_seconds == '0) ? SHORT_RELAX_MS :
	                      PERIOD_W'(PERIOD_W'(cfg.relax_seconds) * MS_PER_S);

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (cmd)
			CMD_TICK: begin
				if (tick_live) begin
					if (off_pend_q) begin
						mode_d = MODE_OFF;
					end else begin
						case (mode_q)
							MODE_TEST:  if (wished) mode_d = MODE_UP;
							MODE_UP:    if (up_done) mode_d = MODE_HOLD;
							MODE_HOLD:  if (hold_done) mode_d = MODE_DOWN;
							MODE_DOWN:  if (down_done) mode_d = MODE_RELAX;
							MODE_RELAX: mode_d = MODE_UP;
							default: begin
							end
						endcase
					end
				end
			end
			CMD_BEGIN:    if (mode_q == MODE_OFF) mode_d = MODE_TEST;
			CMD_CLIP_OFF: if (in_cycle || (mode_q == MODE_TEST)) mode_d = MODE_CLIP;
			CMD_CLIP_ON:  if (mode_q == MODE_CLIP) mode_d = MODE_TEST;
			CMD_CHG_ON:   if (mode_q != MODE_CHARGE) mode_d = MODE_CHARGE;
			CMD_CHG_OFF:  if (mode_q == MODE_CHARGE) mode_d = MODE_OFF;
			CMD_PWR_DIS:  if (in_cycle) mode_d = MODE_TEST;
			default: begin
			end
		endcase
	end

	// counters, flags and per-beat strobes
	always_comb begin
		frame_d    = frame_q;
		cycle_d    = cycle_q;
		off_pend_d = off_pend_q;
		hv_d       = hv_q;
		run_d      = run_q;
		tick_en_d  = tick_en_q;
		period_d   = period_q;
		bank_d     = bank_q;
		pcmd       = PCMD_NONE;
		burst      = 1'b0;
		desc       = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (tick_live) begin
					if (off_pend_q) begin
						hv_d       = 1'b0;
						run_d      = 1'b0;
						off_pend_d = 1'b0;
						tick_en_d  = 1'b0;
					end else begin
						case (mode_q)
							MODE_TEST: begin
								if (wished) begin
									hv_d     = 1'b1;
									run_d    = 1'b1;
									period_d = frame_period;
									frame_d  = '0;
									cycle_d  = '0;
									pcmd     = PCMD_ZERO_UP;
									burst    = 1'b1;
								end
							end
							MODE_UP: begin
								period_d = frame_period;
								burst    = 1'b1;
								if (up_done) begin
									frame_d = '0;
									pcmd    = PCMD_SYNC;
								end else begin
									frame_d = frame_inc;
									pcmd    = PCMD_UP;
								end
							end
							MODE_HOLD: begin
								period_d = frame_period;
								burst    = 1'b1;
								if (cfg.hold_frames != '0) frame_d = frame_inc;
								if (hold_done) begin
									frame_d = '0;
								end else begin
									pcmd = PCMD_SYNC;
								end
							end
							MODE_DOWN: begin
								frame_d = frame_inc;
								if (down_done) begin
									period_d = relax_period;
									pcmd     = PCMD_ZERO;
									desc     = 1'b1;
								end else begin
									period_d = frame_period;
									pcmd     = PCMD_DOWN;
									burst    = 1'b1;
								end
							end
							MODE_RELAX: begin
								// end of one full cycle, bank may flip
								if (cfg.cycles_per_bank != '0) begin
									if (cycle_inc_x >= CMP_W'(cfg.cycles_per_bank)) begin
										bank_d  = ~bank_q;
										cycle_d = '0;
									end else begin
										cycle_d = cycle_inc;
									end
								end
								period_d = frame_period;
								frame_d  = '0;
								pcmd     = PCMD_UP;
								burst    = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end
			CMD_BEGIN: begin
				if (mode_q == MODE_OFF) begin
					period_d  = TEST_PERIOD_MS;
					tick_en_d = 1'b1;
				end
			end
			CMD_TURN_OFF: off_pend_d = 1'b1;
			CMD_CLIP_OFF: begin
				if (in_cycle || (mode_q == MODE_TEST)) begin
					hv_d       = 1'b0;
					run_d      = 1'b0;
					off_pend_d = 1'b0;
					tick_en_d  = 1'b0;
				end
			end
			CMD_CLIP_ON: begin
				if (mode_q == MODE_CLIP) begin
					period_d  = TEST_PERIOD_MS;
					tick_en_d = 1'b1;
				end
			end
			CMD_CHG_ON: begin
				if (mode_q != MODE_CHARGE) begin
					hv_d       = 1'b0;
					run_d      = 1'b0;
					off_pend_d = 1'b0;
					tick_en_d  = 1'b0;
				end
			end
			CMD_PWR_DIS: begin
				if (in_cycle) begin
					period_d  = TEST_PERIOD_MS;
					tick_en_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			frame_q    <= '0;
			cycle_q    <= '0;
			off_pend_q <= 1'b0;
			hv_q       <= 1'b0;
			run_q      <= 1'b0;
			tick_en_q  <= 1'b0;
			period_q   <= '0;
			bank_q     <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			frame_q    <= frame_d;
			cycle_q    <= cycle_d;
			off_pend_q <= off_pend_d;
			hv_q       <= hv_d;
			run_q      <= run_d;
			tick_en_q  <= tick_en_d;
			period_q   <= period_d;
			bank_q     <= bank_d;
		end
	end

	always_comb begin
		result.mode            = mode_d;
		result.power_cmd       = pcmd;
		result.high_voltage_on = hv_d;
		result.running         = run_d;
		result.tick_enable     = tick_en_d;
		result.tick_period_ms  = period_d;
		result.burst_start     = burst;
		result.descent_start   = desc;
		result.bank            = bank_d;
	end

endmodule

[hw/rtl/scs_skid.sv]
// ----------------------------------------------------------------------------
// scs_skid
// Output register with one skid entry between core and result channel.
// ----------------------------------------------------------------------------
module scs_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  scs_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output scs_pkg::result_t out_data
);
	import scs_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;
	logic    in_fire, out_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_fire) begin
				out_data_q <= in_data;
			end
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule

[hw/rtl/stimulation_cycle_sequencer.sv]
// ----------------------------------------------------------------------------
// stimulation_cycle_sequencer
// Event driven sequencer of the stimulation cycle: one status word per event.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_ stream: s_tuser carries the command, s_tdata[0]
//   the wished-power flag. Each accepted beat yields exactly one status beat
//   on the m_ stream, in order.
//   A beat's status is registered in the output register, or in the skid entry
//   while the output stalls. Throughput is one event per cycle while m_tready is
//   high; the mode and counter update is one registered pass through the core logic.
//   If m_tready is held low, one more event is taken into the skid entry,
//   after which s_tready drops until the output drains.
//   Configuration writes on cfg_ are always ready and must be issued only
//   while no event is in flight.
//   After arst_n the mode is off, counters, flags, tick period and bank are
//   zero, and the registers hold their defaults (period 100 ms, ramp up 10,
//   hold 20, ramp down 10 frames, relax 1 s, no bank toggling).
// ----------------------------------------------------------------------------
module stimulation_cycle_sequencer #(
	parameter int COUNTER_WIDTH = scs_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // wished_power_nonzero, zero fill
	input  logic [2:0]                    s_tuser,   // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mode, power_cmd, high_voltage_on, running, tick_enable, tick_period_ms,
	// burst_start, descent_start, bank, zero fill
	output logic [31:0]                   m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scs_pkg::CFG_W-1:0]     cfg_data
);
	import scs_pkg::*;

	cfg_t    cfg;
	result_t core_res, out_res;
	logic    s_fire;

	assign s_fire = s_tvalid && s_tready;

	scs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	scs_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s_fire),
		.cmd    (cmd_t'(s_tuser)),
		.wished (s_tdata[0]),
		.cfg    (cfg),
		.result (core_res)
	);

	scs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {2'b00, out_res.bank, out_res.descent_start, out_res.burst_start,
	                  out_res.tick_period_ms, out_res.tick_enable, out_res.running,
	                  out_res.high_voltage_on, out_res.power_cmd, out_res.mode};

`ifndef SYNTH
	// a stalled input means the skid entry is full behind a waiting beat
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending output beat");

	a_burst_desc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[27] && m_tdata[28]))
		else $error("burst and descent start in one beat");

	a_running_needs_hv: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7]) |-> m_tdata[6])
		else $error("running without high voltage");

	a_active_tick_en: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ((m_tdata[2:0] == MODE_TEST) || (m_tdata[2:0] == MODE_UP) ||
		              (m_tdata[2:0] == MODE_HOLD) || (m_tdata[2:0] == MODE_DOWN) ||
		              (m_tdata[2:0] == MODE_RELAX))) |-> m_tdata[8])
		else $error("active mode with tick timer disabled");
`endif

endmodule
